### sv/cole_pkg.sv
package cole_pkg;

    localparam int ITEM_W    = 32;
    localparam int SUM_W     = 37;
    localparam int IDX_W     = 5;
    localparam int CMD_W     = 4;
    localparam int OUT_CNT_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_START      = 4'd0,
        CMD_END        = 4'd1,
        CMD_ADVANCE    = 4'd2,
        CMD_RETREAT    = 4'd3,
        CMD_INSERT     = 4'd4,
        CMD_ATTACH     = 4'd5,
        CMD_REMOVE_CUR = 4'd6,
        CMD_INS_FRONT  = 4'd7,
        CMD_ATT_BACK   = 4'd8,
        CMD_REM_FRONT  = 4'd9,
        CMD_READ_INDEX = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK     = 2'd0,
        ERR_FULL   = 2'd1,
        ERR_NO_CUR = 2'd2,
        ERR_RANGE  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ZERO,
        CUR_LAST,
        CUR_INC,
        CUR_DEC
    } cur_op_t;

    typedef enum logic [1:0] {
        POS_CURSOR,
        POS_AFTER,
        POS_ZERO,
        POS_COUNT
    } pos_sel_t;

    typedef enum logic [1:0] {
        RD_PTR,
        RD_CURSOR,
        RD_INDEX
    } rd_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_SHUP,
        S_UP_DRAIN,
        S_PUT,
        S_TAKE,
        S_SHDN,
        S_DN_DRAIN,
        S_READ,
        S_CAP
    } state_t;

    typedef struct packed {
        logic     latch;
        logic     err_load;
        err_t     err_code;
        cur_op_t  cur_op;
        pos_sel_t pos_sel;
        logic     setup_up;
        logic     setup_dn;
        logic     shift_up;
        logic     take;
        logic     shift_dn;
        logic     put;
        logic     cnt_dec;
        rd_src_t  rd_src;
        logic     by_index;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             cnt_zero;
        logic             cur_valid;
        logic             cur_zero;
        logic             full;
        logic             idx_ok;
        logic             pos_at_end;
        logic             up_last;
        logic             dn_last;
        logic             out_busy;
    } dp_stat_t;

endpackage

### sv/cole_store.sv
module cole_store
    import cole_pkg::*;
#(
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [ITEM_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [ITEM_W-1:0]        rd_data
);

    logic [ITEM_W-1:0] mem [DEPTH];
    logic [ITEM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/cole_dp.sv
module cole_dp
    import cole_pkg::*;
#(
    parameter int CAPACITY_ITEMS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [ITEM_W-1:0]    value,
    input  logic [IDX_W-1:0]     index,
    input  dp_cmd_t              ctl,
    output dp_stat_t             st,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ITEM_W-1:0]    item,
    output logic [OUT_CNT_W-1:0] count,
    output logic [OUT_CNT_W-1:0] cursor,
    output logic                 cursor_valid,
    output logic [SUM_W-1:0]     total,
    output logic [1:0]           error
);

    localparam int ADDR_W = $clog2(CAPACITY_ITEMS);
    localparam int CNT_W  = $clog2(CAPACITY_ITEMS + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int OUT_W  = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;

    logic [CMD_W-1:0]     cmd_reg;
    logic [ITEM_W-1:0]    val_reg;
    logic [IDX_W-1:0]     idx_reg;
    err_t                 err_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     cursor_reg, cursor_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [ADDR_W-1:0]    ptr_reg, ptr_next;
    logic [ADDR_W-1:0]    wptr_reg, wptr_next;
    logic [ADDR_W-1:0]    pos_reg;
    logic                 pend_reg;
    logic                 sub_reg;

    logic                 out_valid_reg;
    logic [ITEM_W-1:0]    out_item_reg;
    logic [OUT_CNT_W-1:0] out_count_reg;
    logic [OUT_CNT_W-1:0] out_cursor_reg;
    logic                 out_cv_reg;
    logic [SUM_W-1:0]     out_total_reg;
    err_t                 out_err_reg;

    logic [OUT_W-1:0]     cnt_ext, cur_ext;
    logic [CMP_W-1:0]     idx_cmp, cnt_cmp;
    logic [CNT_W-1:0]     cnt_m1, pos_wide, ptr_ext;
    logic [ADDR_W-1:0]    pos_calc;
    logic                 cur_valid, idx_ok, item_ok;
    logic [SUM_W-1:0]     val_sx, rd_sx;

    logic                 we;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [ITEM_W-1:0]    wr_data, rd_data;

    cole_store #(
        .DEPTH(CAPACITY_ITEMS)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    assign cnt_ext   = OUT_W'(count_reg);
    assign cur_ext   = OUT_W'(cursor_reg);
    assign idx_cmp   = CMP_W'(idx_reg);
    assign cnt_cmp   = CMP_W'(count_reg);
    assign cur_valid = cursor_reg < count_reg;
    assign idx_ok    = idx_cmp < cnt_cmp;
    assign cnt_m1    = count_reg - CNT_W'(1);
    assign ptr_ext   = CNT_W'(ptr_reg);
    assign val_sx    = {{(SUM_W-ITEM_W){val_reg[ITEM_W-1]}}, val_reg};
    assign rd_sx     = {{(SUM_W-ITEM_W){rd_data[ITEM_W-1]}}, rd_data};
    assign item_ok   = ctl.by_index ? idx_ok : cur_valid;

    always_comb
    begin
        case (ctl.pos_sel)
            POS_CURSOR: pos_wide = cursor_reg;
            POS_AFTER:  pos_wide = cursor_reg + CNT_W'(1);
            POS_ZERO:   pos_wide = '0;
            POS_COUNT:  pos_wide = count_reg;
            default:    pos_wide = '0;
        endcase
    end

    assign pos_calc = pos_wide[ADDR_W-1:0];

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.cnt_zero   = count_reg == '0;
        st.cur_valid  = cur_valid;
        st.cur_zero   = cursor_reg == '0;
        st.full       = count_reg == CNT_W'(CAPACITY_ITEMS);
        st.idx_ok     = idx_ok;
        st.pos_at_end = pos_wide == count_reg;
        st.up_last    = ptr_reg == pos_reg;
        st.dn_last    = (ptr_ext + CNT_W'(1)) == count_reg;
        st.out_busy   = out_valid_reg && !out_ready;
    end

    // write port: shifted entry in the cycle after its read, or the new item
    assign we      = pend_reg || ctl.put;
    assign wr_addr = ctl.put ? pos_reg : wptr_reg;
    assign wr_data = ctl.put ? val_reg : rd_data;

    always_comb
    begin
        case (ctl.rd_src)
            RD_PTR:    rd_addr = ptr_reg;
            RD_CURSOR: rd_addr = cursor_reg[ADDR_W-1:0];
            RD_INDEX:  rd_addr = idx_cmp[ADDR_W-1:0];
            default:   rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.put)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.cnt_dec)
        begin
            count_next = cnt_m1;
        end

        cursor_next = cursor_reg;
        if (ctl.put)
        begin
            cursor_next = CNT_W'(pos_reg);
        end
        else
        begin
            case (ctl.cur_op)
                CUR_HOLD: cursor_next = cursor_reg;
                CUR_ZERO: cursor_next = '0;
                CUR_LAST: cursor_next = cnt_m1;
                CUR_INC:  cursor_next = cursor_reg + CNT_W'(1);
                CUR_DEC:  cursor_next = cursor_reg - CNT_W'(1);
                default:  cursor_next = cursor_reg;
            endcase
        end

        sum_next = sum_reg;
        if (ctl.put)
        begin
            sum_next = sum_reg + val_sx;
        end
        else if (sub_reg)
        begin
            sum_next = sum_reg - rd_sx;
        end

        ptr_next  = ptr_reg;
        wptr_next = wptr_reg;
        if (ctl.setup_up)
        begin
            ptr_next = cnt_m1[ADDR_W-1:0];
        end
        else if (ctl.setup_dn)
        begin
            ptr_next = pos_calc;
        end
        else if (ctl.shift_up)
        begin
            ptr_next  = ptr_reg - ADDR_W'(1);
            wptr_next = ptr_reg + ADDR_W'(1);
        end
        else if (ctl.shift_dn)
        begin
            ptr_next  = ptr_reg + ADDR_W'(1);
            wptr_next = ptr_reg - ADDR_W'(1);
        end
        else if (ctl.take)
        begin
            ptr_next = ptr_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            sum_reg       <= '0;
            pend_reg      <= 1'b0;
            sub_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            sum_reg    <= sum_next;
            pend_reg   <= ctl.shift_up || ctl.shift_dn;
            sub_reg    <= ctl.take;
            if (ctl.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        wptr_reg <= wptr_next;
        if (ctl.latch)
        begin
            cmd_reg <= cmd;
            val_reg <= value;
            idx_reg <= index;
        end
        if (ctl.err_load)
        begin
            err_reg <= ctl.err_code;
        end
        if (ctl.setup_up || ctl.setup_dn)
        begin
            pos_reg <= pos_calc;
        end
        if (ctl.load_out)
        begin
            out_item_reg   <= item_ok ? rd_data : '0;
            out_count_reg  <= cnt_ext[OUT_CNT_W-1:0];
            out_cursor_reg <= cur_ext[OUT_CNT_W-1:0];
            out_cv_reg     <= cur_valid;
            out_total_reg  <= sum_reg;
            out_err_reg    <= err_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign item         = out_item_reg;
    assign count        = out_count_reg;
    assign cursor       = out_cursor_reg;
    assign cursor_valid = out_cv_reg;
    assign total        = out_total_reg;
    assign error        = out_err_reg;

endmodule

### sv/cole_ctrl.sv
module cole_ctrl
    import cole_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t st,
    output dp_cmd_t  ctl
);

    state_t state_reg, state_next;
    logic   by_index;

    assign by_index = st.cmd == CMD_READ_INDEX;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctl          = '0;
        ctl.err_code = ERR_OK;
        ctl.cur_op   = CUR_HOLD;
        ctl.pos_sel  = POS_CURSOR;
        ctl.rd_src   = RD_PTR;
        ctl.by_index = by_index;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.latch  = 1'b1;
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                ctl.err_load = 1'b1;
                state_next   = S_READ;
                case (st.cmd)
                    CMD_START:
                    begin
                        if (!st.cnt_zero)
                        begin
                            ctl.cur_op = CUR_ZERO;
                        end
                    end
                    CMD_END:
                    begin
                        if (!st.cnt_zero)
                        begin
                            ctl.cur_op = CUR_LAST;
                        end
                    end
                    CMD_ADVANCE:
                    begin
                        if (st.cur_valid)
                        begin
                            ctl.cur_op = CUR_INC;
                        end
                        else
                        begin
                            ctl.err_code = ERR_NO_CUR;
                        end
                    end
                    CMD_RETREAT:
                    begin
                        if (!st.cur_zero)
                        begin
                            ctl.cur_op = CUR_DEC;
                        end
                    end
                    CMD_INSERT, CMD_ATTACH, CMD_INS_FRONT, CMD_ATT_BACK:
                    begin
                        if (st.cmd == CMD_INSERT)
                        begin
                            ctl.pos_sel = st.cur_valid ? POS_CURSOR : POS_COUNT;
                        end
                        else if (st.cmd == CMD_ATTACH)
                        begin
                            ctl.pos_sel = st.cur_valid ? POS_AFTER : POS_COUNT;
                        end
                        else if (st.cmd == CMD_INS_FRONT)
                        begin
                            ctl.pos_sel = POS_ZERO;
                        end
                        else
                        begin
                            ctl.pos_sel = POS_COUNT;
                        end
                        if (st.full)
                        begin
                            ctl.err_code = ERR_FULL;
                        end
                        else
                        begin
                            ctl.setup_up = 1'b1;
                            state_next   = st.pos_at_end ? S_PUT : S_SHUP;
                        end
                    end
                    CMD_REMOVE_CUR:
                    begin
                        ctl.pos_sel = POS_CURSOR;
                        if (st.cur_valid)
                        begin
                            ctl.setup_dn = 1'b1;
                            state_next   = S_TAKE;
                        end
                        else
                        begin
                            ctl.err_code = ERR_NO_CUR;
                        end
                    end
                    CMD_REM_FRONT:
                    begin
                        ctl.pos_sel = POS_ZERO;
                        if (st.cnt_zero)
                        begin
                            ctl.err_code = ERR_NO_CUR;
                        end
                        else
                        begin
                            ctl.cur_op   = CUR_ZERO;
                            ctl.setup_dn = 1'b1;
                            state_next   = S_TAKE;
                        end
                    end
                    CMD_READ_INDEX:
                    begin
                        if (!st.idx_ok)
                        begin
                            ctl.err_code = ERR_RANGE;
                        end
                    end
                    default:
                    begin
                        ctl.err_code = ERR_OK;
                    end
                endcase
            end

            S_SHUP:
            begin
                ctl.shift_up = 1'b1;
                ctl.rd_src   = RD_PTR;
                if (st.up_last)
                begin
                    state_next = S_UP_DRAIN;
                end
            end

            S_UP_DRAIN:
            begin
                state_next = S_PUT;
            end

            S_PUT:
            begin
                ctl.put    = 1'b1;
                state_next = S_READ;
            end

            S_TAKE:
            begin
                ctl.take   = 1'b1;
                ctl.rd_src = RD_PTR;
                state_next = st.dn_last ? S_DN_DRAIN : S_SHDN;
            end

            S_SHDN:
            begin
                ctl.shift_dn = 1'b1;
                ctl.rd_src   = RD_PTR;
                if (st.dn_last)
                begin
                    state_next = S_DN_DRAIN;
                end
            end

            S_DN_DRAIN:
            begin
                ctl.cnt_dec = 1'b1;
                state_next  = S_READ;
            end

            S_READ:
            begin
                ctl.rd_src = by_index ? RD_INDEX : RD_CURSOR;
                state_next = S_CAP;
            end

            S_CAP:
            begin
                ctl.rd_src = by_index ? RD_INDEX : RD_CURSOR;
                if (!st.out_busy)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/cursor_ordered_list_engine.sv
// Bounded ordered list of signed 32-bit items with a cursor, held in a single-port-write,
// single-port-read memory of CAPACITY_ITEMS entries. One command is taken at a time and
// gives exactly one result transaction. Cursor moves, reads by index, and any command
// that ends in an error move no entries; an insert moves the held entries from its
// position on up by one place, and a remove moves the count - position - 1 entries
// after it down by one place. Shifting runs at one entry per cycle through the memory's
// registered read port, and the next command can be taken as soon as the result is
// registered, even while that result is still waiting to be taken.
module cursor_ordered_list_engine
    import cole_pkg::*;
#(
    parameter int CAPACITY_ITEMS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [CMD_W-1:0]     cmd,
    input  logic [ITEM_W-1:0]    value,
    input  logic [IDX_W-1:0]     index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ITEM_W-1:0]    item,
    output logic [OUT_CNT_W-1:0] count,
    output logic [OUT_CNT_W-1:0] cursor,
    output logic                 cursor_valid,
    output logic [SUM_W-1:0]     total,
    output logic [1:0]           error
);

    dp_cmd_t  ctl;
    dp_stat_t st;

    cole_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .st      (st),
        .ctl     (ctl)
    );

    cole_dp #(
        .CAPACITY_ITEMS(CAPACITY_ITEMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .value       (value),
        .index       (index),
        .ctl         (ctl),
        .st          (st),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .item        (item),
        .count       (count),
        .cursor      (cursor),
        .cursor_valid(cursor_valid),
        .total       (total),
        .error       (error)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second transaction taken while a command is in progress");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (CAPACITY_ITEMS < 64)) |-> (cursor <= count))
        else $error("cursor beyond item count");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (error == ERR_FULL)) |-> (count == OUT_CNT_W'(CAPACITY_ITEMS)))
        else $error("list full reported below capacity");

    a_no_item_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((error == ERR_RANGE) || (!cursor_valid && (error == ERR_NO_CUR))))
        |-> (item == '0))
        else $error("item not zero when nothing was read");

endmodule
